[rtl/tcp_pkg.sv]
`default_nettype none

package tcp_pkg;

	// field and register widths
	localparam int COORD_W         = 32;
	localparam int DIST_W          = 31;
	localparam int WIN_W           = 14;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	// default fraction bits of the coordinate format
	localparam int COORD_FRAC_BITS = 16;

	// divider geometry: magnitude of d*c over a positive depth
	localparam int NUM_W           = 63;
	localparam int QUO_W           = 32;
	localparam int DIV_STEP_BITS   = 4;
	localparam int DIV_STAGES      = QUO_W / DIV_STEP_BITS;

	// register reset values
	localparam logic [DIST_W-1:0] PLANE_DISTANCE_RST = 31'd65536;
	localparam logic [WIN_W-1:0]  WINDOW_WIDTH_RST   = 14'd640;
	localparam logic [WIN_W-1:0]  WINDOW_HEIGHT_RST  = 14'd480;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLANE_DISTANCE = 3'd0,
		CFG_PLANE_OFFSET_X = 3'd1,
		CFG_PLANE_OFFSET_Y = 3'd2,
		CFG_WINDOW_WIDTH   = 3'd3,
		CFG_WINDOW_HEIGHT  = 3'd4
	} cfg_idx_t;

endpackage

`default_nettype wire

[rtl/tcp_div_lane.sv]
`default_nettype none

module tcp_div_lane (
	input  logic                             clk,
	input  logic [tcp_pkg::DIV_STAGES-1:0]   en,
	input  logic [tcp_pkg::NUM_W-1:0]        num,
	input  logic [tcp_pkg::DIST_W-1:0]       den,
	output logic [tcp_pkg::QUO_W-1:0]        quo
);

	localparam int N     = tcp_pkg::DIV_STAGES;
	localparam int REM_W = tcp_pkg::DIST_W;
	localparam int QW    = tcp_pkg::QUO_W;

	logic [REM_W-1:0]          rem_s [N];
	logic [QW-1:0]             nq_s  [N];
	logic [tcp_pkg::DIST_W-1:0] den_s [N];

	// restoring division, a few quotient bits per stage
	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [REM_W-1:0]           rem_i;
		logic [REM_W-1:0]           rem_o;
		logic [QW-1:0]              nq_i;
		logic [QW-1:0]              nq_o;
		logic [tcp_pkg::DIST_W-1:0] den_i;

		if (k == 0) begin : g_first
			assign rem_i = num[tcp_pkg::NUM_W-1:QW];
			assign nq_i  = num[QW-1:0];
			assign den_i = den;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign nq_i  = nq_s[k-1];
			assign den_i = den_s[k-1];
		end

		// dividend bits shift out of the top as quotient bits enter below
		always_comb begin
			logic [REM_W:0] t;
			rem_o = rem_i;
			nq_o  = nq_i;
			for (int b = 0; b < tcp_pkg::DIV_STEP_BITS; b++) begin
				t    = {rem_o, nq_o[QW-1]};
				nq_o = {nq_o[QW-2:0], 1'b0};
				if (t >= {1'b0, den_i}) begin
					t       = t - {1'b0, den_i};
					nq_o[0] = 1'b1;
				end
				rem_o = t[REM_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_o;
				nq_s[k]  <= nq_o;
				den_s[k] <= den_i;
			end
		end
	end

	assign quo = nq_s[N-1];

endmodule

`default_nettype wire

[rtl/triangle_cull_and_project_top.sv]
// Triangle cull and perspective projection. One triangle item (three camera-space
// vertices and a face normal, signed fixed point) enters per cycle and one result
// item leaves per cycle while the receiver holds out_ready high. The pipeline is
// built around the pipelined divider, 8 stages of 4 quotient bits each, one lane
// per projected coordinate, with three stages ahead of it and three behind. The
// result carries the facing-away, too-near and off-screen flags, the six saturated
// screen coordinates (zero when a cull flag blocks projection) and the three depths
// unchanged. Each stage holds its item while the next is full, so bubbles close up
// and an item is taken while a finished result waits. Registers may be written only
// while the pipeline is empty.
`default_nettype none

module triangle_cull_and_project_top #(
	parameter int COORD_FRAC_BITS = tcp_pkg::COORD_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert0_x,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert0_y,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert0_z,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert1_x,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert1_y,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert1_z,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert2_x,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert2_y,
	input  logic signed [tcp_pkg::COORD_W-1:0] vert2_z,
	input  logic signed [tcp_pkg::COORD_W-1:0] normal_x,
	input  logic signed [tcp_pkg::COORD_W-1:0] normal_y,
	input  logic signed [tcp_pkg::COORD_W-1:0] normal_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               facing_away,
	output logic                               too_near,
	output logic                               off_screen,
	output logic signed [tcp_pkg::COORD_W-1:0] screen0_x,
	output logic signed [tcp_pkg::COORD_W-1:0] screen0_y,
	output logic signed [tcp_pkg::COORD_W-1:0] screen1_x,
	output logic signed [tcp_pkg::COORD_W-1:0] screen1_y,
	output logic signed [tcp_pkg::COORD_W-1:0] screen2_x,
	output logic signed [tcp_pkg::COORD_W-1:0] screen2_y,
	output logic signed [tcp_pkg::COORD_W-1:0] depth0,
	output logic signed [tcp_pkg::COORD_W-1:0] depth1,
	output logic signed [tcp_pkg::COORD_W-1:0] depth2
);

	localparam int CW     = tcp_pkg::COORD_W;
	localparam int NSTG   = 11 + tcp_pkg::DIV_STAGES - 8 + 3;
	localparam int DIV0   = 4;
	localparam int DIVN   = tcp_pkg::DIV_STAGES;
	localparam int HW_W   = tcp_pkg::WIN_W + COORD_FRAC_BITS - 1;
	localparam int CMP_W  = ((HW_W > CW) ? HW_W : CW) + 2;

	typedef struct packed {
		logic              away;
		logic              near;
		logic [2:0]        zok;
		logic [5:0]        neg;
		logic [2:0][CW-1:0] depth;
	} side_t;

	// configuration registers
	logic [tcp_pkg::DIST_W-1:0] dist_q;
	logic signed [CW-1:0]       off_x_q;
	logic signed [CW-1:0]       off_y_q;
	logic [tcp_pkg::WIN_W-1:0]  win_w_q;
	logic [tcp_pkg::WIN_W-1:0]  win_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= tcp_pkg::PLANE_DISTANCE_RST;
			off_x_q <= '0;
			off_y_q <= '0;
			win_w_q <= tcp_pkg::WINDOW_WIDTH_RST;
			win_h_q <= tcp_pkg::WINDOW_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tcp_pkg::CFG_PLANE_DISTANCE: dist_q  <= cfg_data[tcp_pkg::DIST_W-1:0];
				tcp_pkg::CFG_PLANE_OFFSET_X: off_x_q <= $signed(cfg_data);
				tcp_pkg::CFG_PLANE_OFFSET_Y: off_y_q <= $signed(cfg_data);
				tcp_pkg::CFG_WINDOW_WIDTH:   win_w_q <= cfg_data[tcp_pkg::WIN_W-1:0];
				tcp_pkg::CFG_WINDOW_HEIGHT:  win_h_q <= cfg_data[tcp_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valid bits and load enables
	logic [NSTG:1]   valid_s;
	logic [NSTG+1:1] en;

	always_comb begin
		en[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[1]) begin
				valid_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = valid_s[NSTG];

	// stage 1: capture item and near test
	logic signed [CW-1:0] vx_s1 [3];
	logic signed [CW-1:0] vy_s1 [3];
	logic signed [CW-1:0] vz_s1 [3];
	logic signed [CW-1:0] n_s1  [3];
	logic                 near_s1;
	logic signed [CW:0]   dist_sx;

	assign dist_sx = $signed({2'b00, dist_q});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vx_s1[0] <= vert0_x; vy_s1[0] <= vert0_y; vz_s1[0] <= vert0_z;
			vx_s1[1] <= vert1_x; vy_s1[1] <= vert1_y; vz_s1[1] <= vert1_z;
			vx_s1[2] <= vert2_x; vy_s1[2] <= vert2_y; vz_s1[2] <= vert2_z;
			n_s1[0]  <= normal_x;
			n_s1[1]  <= normal_y;
			n_s1[2]  <= normal_z;
			near_s1  <= ($signed({vert0_z[CW-1], vert0_z}) < dist_sx) ||
				($signed({vert1_z[CW-1], vert1_z}) < dist_sx) ||
				($signed({vert2_z[CW-1], vert2_z}) < dist_sx);
		end
	end

	// stage 2: dot products and projection numerators
	logic signed [2*CW-1:0] dprod_s2 [3];
	logic signed [2*CW-1:0] nprod_s2 [6];
	logic signed [CW-1:0]   vz_s2    [3];
	logic                   near_s2;
	logic signed [CW-1:0]   dist_s;

	assign dist_s = $signed({1'b0, dist_q});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dprod_s2[0] <= 64'(64'(vx_s1[0]) * 64'(n_s1[0]));
			dprod_s2[1] <= 64'(64'(vy_s1[0]) * 64'(n_s1[1]));
			dprod_s2[2] <= 64'(64'(vz_s1[0]) * 64'(n_s1[2]));
			for (int i = 0; i < 3; i++) begin
				nprod_s2[2*i]   <= 64'(64'(dist_s) * 64'(vx_s1[i]));
				nprod_s2[2*i+1] <= 64'(64'(dist_s) * 64'(vy_s1[i]));
				vz_s2[i]        <= vz_s1[i];
			end
			near_s2 <= near_s1;
		end
	end

	// stage 3: exact dot sign, numerator magnitudes
	side_t                      side_s3;
	logic [tcp_pkg::NUM_W-1:0]  num_s3 [6];
	logic [tcp_pkg::DIST_W-1:0] den_s3 [3];
	logic signed [2*CW+1:0]     dot_sum;

	assign dot_sum = $signed({{2{dprod_s2[0][2*CW-1]}}, dprod_s2[0]}) +
		$signed({{2{dprod_s2[1][2*CW-1]}}, dprod_s2[1]}) +
		$signed({{2{dprod_s2[2][2*CW-1]}}, dprod_s2[2]});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			side_s3.away <= !dot_sum[2*CW+1];
			side_s3.near <= near_s2;
			for (int j = 0; j < 6; j++) begin
				side_s3.neg[j] <= nprod_s2[j][2*CW-1];
				num_s3[j]      <= nprod_s2[j][2*CW-1] ? 63'(-nprod_s2[j]) : 63'(nprod_s2[j]);
			end
			for (int i = 0; i < 3; i++) begin
				side_s3.zok[i]   <= (vz_s2[i] != '0);
				side_s3.depth[i] <= vz_s2[i];
				den_s3[i]        <= vz_s2[i][tcp_pkg::DIST_W-1:0];
			end
		end
	end

	// stages 4 to 11: divider lanes, flags and depths ride alongside
	logic [tcp_pkg::QUO_W-1:0] quo [6];
	side_t                     side_div_s [DIVN];

	for (genvar j = 0; j < 6; j++) begin : g_lane
		tcp_div_lane u_div (
			.clk (clk),
			.en  (en[DIV0 +: DIVN]),
			.num (num_s3[j]),
			.den (den_s3[j/2]),
			.quo (quo[j])
		);
	end

	always_ff @(posedge clk) begin
		if (en[DIV0]) begin
			side_div_s[0] <= side_s3;
		end
		for (int k = 1; k < DIVN; k++) begin
			if (en[DIV0+k]) begin
				side_div_s[k] <= side_div_s[k-1];
			end
		end
	end

	// sign, offset and saturation of one coordinate
	function automatic logic signed [CW-1:0] place(
		input logic [tcp_pkg::QUO_W-1:0] q,
		input logic                      neg,
		input logic                      zok,
		input logic signed [CW-1:0]      offs
	);
		logic signed [CW:0]   qs;
		logic signed [CW+1:0] sum;
		qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (!zok) begin
			qs = '0;
		end
		sum = $signed({qs[CW], qs}) + $signed({{2{offs[CW-1]}}, offs});
		if (sum > $signed({2'b00, {(CW-1){1'b1}}})) begin
			place = {1'b0, {(CW-1){1'b1}}};
		end else if (sum < $signed({2'b11, {(CW-1){1'b0}}})) begin
			place = {1'b1, {(CW-1){1'b0}}};
		end else begin
			place = sum[CW-1:0];
		end
	endfunction

	// stage 12: screen coordinates
	localparam int S12 = DIV0 + DIVN;
	side_t                side_s12;
	logic signed [CW-1:0] sx_s12 [3];
	logic signed [CW-1:0] sy_s12 [3];

	always_ff @(posedge clk) begin
		if (en[S12]) begin
			side_s12 <= side_div_s[DIVN-1];
			for (int i = 0; i < 3; i++) begin
				sx_s12[i] <= place(quo[2*i], side_div_s[DIVN-1].neg[2*i],
					side_div_s[DIVN-1].zok[i], off_x_q);
				sy_s12[i] <= place(quo[2*i+1], side_div_s[DIVN-1].neg[2*i+1],
					side_div_s[DIVN-1].zok[i], off_y_q);
			end
		end
	end

	// stage 13: bounding box
	function automatic logic signed [CW-1:0] min3(
		input logic signed [CW-1:0] a, b, c
	);
		logic signed [CW-1:0] m;
		m    = (a < b) ? a : b;
		min3 = (m < c) ? m : c;
	endfunction

	function automatic logic signed [CW-1:0] max3(
		input logic signed [CW-1:0] a, b, c
	);
		logic signed [CW-1:0] m;
		m    = (a > b) ? a : b;
		max3 = (m > c) ? m : c;
	endfunction

	side_t                side_s13;
	logic signed [CW-1:0] sx_s13 [3];
	logic signed [CW-1:0] sy_s13 [3];
	logic signed [CW-1:0] minx_s13, maxx_s13, miny_s13, maxy_s13;

	always_ff @(posedge clk) begin
		if (en[S12+1]) begin
			side_s13 <= side_s12;
			sx_s13   <= sx_s12;
			sy_s13   <= sy_s12;
			minx_s13 <= min3(sx_s12[0], sx_s12[1], sx_s12[2]);
			maxx_s13 <= max3(sx_s12[0], sx_s12[1], sx_s12[2]);
			miny_s13 <= min3(sy_s12[0], sy_s12[1], sy_s12[2]);
			maxy_s13 <= max3(sy_s12[0], sy_s12[1], sy_s12[2]);
		end
	end

	// stage 14: window test, blocked items give zero coordinates
	logic signed [CMP_W-1:0] hw, hh;
	logic                    inside_win;
	logic                    blocked;

	function automatic logic signed [CMP_W-1:0] ext(input logic signed [CW-1:0] v);
		ext = $signed({{(CMP_W-CW){v[CW-1]}}, v});
	endfunction

	assign hw = $signed({{(CMP_W-HW_W){1'b0}}, win_w_q, {(COORD_FRAC_BITS-1){1'b0}}});
	assign hh = $signed({{(CMP_W-HW_W){1'b0}}, win_h_q, {(COORD_FRAC_BITS-1){1'b0}}});
	assign inside_win = (-hw < ext(maxx_s13)) && (hw > ext(minx_s13)) &&
		(-hh < ext(maxy_s13)) && (hh > ext(miny_s13));
	assign blocked = side_s13.away || side_s13.near;

	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			facing_away <= side_s13.away;
			too_near    <= side_s13.near;
			off_screen  <= !blocked && !inside_win;
			screen0_x   <= blocked ? '0 : sx_s13[0];
			screen0_y   <= blocked ? '0 : sy_s13[0];
			screen1_x   <= blocked ? '0 : sx_s13[1];
			screen1_y   <= blocked ? '0 : sy_s13[1];
			screen2_x   <= blocked ? '0 : sx_s13[2];
			screen2_y   <= blocked ? '0 : sy_s13[2];
			depth0      <= side_s13.depth[0];
			depth1      <= side_s13.depth[1];
			depth2      <= side_s13.depth[2];
		end
	end

endmodule

`default_nettype wire

[dv/triangle_cull_and_project_top_tb.sv]
`default_nettype none

module triangle_cull_and_project_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// field order of one triangle: v0 xyz, v1 xyz, v2 xyz, normal xyz
	typedef struct {
		logic signed [tcp_pkg::COORD_W-1:0] c [12];
	} tri_t;

	// field order of one result: flags, screen xy per vertex, depths
	typedef struct {
		logic signed [tcp_pkg::COORD_W-1:0] f [12];
	} proj_t;

	typedef struct {
		tri_t  t;
		bit    typed;
		proj_t r;
	} row_t;

	localparam logic [tcp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 235;

	const string field_name [12] = '{"facing_away", "too_near", "off_screen",
		"screen0_x", "screen0_y", "screen1_x", "screen1_y", "screen2_x",
		"screen2_y", "depth0", "depth1", "depth2"};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic facing_away, too_near, off_screen;
	logic signed [tcp_pkg::COORD_W-1:0] screen0_x, screen0_y, screen1_x, screen1_y;
	logic signed [tcp_pkg::COORD_W-1:0] screen2_x, screen2_y, depth0, depth1, depth2;
	logic signed [tcp_pkg::COORD_W-1:0] vert0_x, vert0_y, vert0_z;
	logic signed [tcp_pkg::COORD_W-1:0] vert1_x, vert1_y, vert1_z;
	logic signed [tcp_pkg::COORD_W-1:0] vert2_x, vert2_y, vert2_z;
	logic signed [tcp_pkg::COORD_W-1:0] normal_x, normal_y, normal_z;

	tri_t cur_tri;

	// shadow copy of the block's registers
	logic [tcp_pkg::DIST_W-1:0]         sh_dist = tcp_pkg::PLANE_DISTANCE_RST;
	logic signed [tcp_pkg::COORD_W-1:0] sh_off_x = '0;
	logic signed [tcp_pkg::COORD_W-1:0] sh_off_y = '0;
	logic [tcp_pkg::WIN_W-1:0]          sh_win_w = tcp_pkg::WINDOW_WIDTH_RST;
	logic [tcp_pkg::WIN_W-1:0]          sh_win_h = tcp_pkg::WINDOW_HEIGHT_RST;

	proj_t pending_results [$];
	int    n_taken = 0;
	int    errors = 0;
	int    stuck_cycles = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	bit    running = 1'b0;

	assign vert0_x = cur_tri.c[0];
	assign vert0_y = cur_tri.c[1];
	assign vert0_z = cur_tri.c[2];
	assign vert1_x = cur_tri.c[3];
	assign vert1_y = cur_tri.c[4];
	assign vert1_z = cur_tri.c[5];
	assign vert2_x = cur_tri.c[6];
	assign vert2_y = cur_tri.c[7];
	assign vert2_z = cur_tri.c[8];
	assign normal_x = cur_tri.c[9];
	assign normal_y = cur_tri.c[10];
	assign normal_z = cur_tri.c[11];

	triangle_cull_and_project_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.vert0_x(vert0_x), .vert0_y(vert0_y), .vert0_z(vert0_z),
		.vert1_x(vert1_x), .vert1_y(vert1_y), .vert1_z(vert1_z),
		.vert2_x(vert2_x), .vert2_y(vert2_y), .vert2_z(vert2_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.facing_away(facing_away), .too_near(too_near), .off_screen(off_screen),
		.screen0_x(screen0_x), .screen0_y(screen0_y),
		.screen1_x(screen1_x), .screen1_y(screen1_y),
		.screen2_x(screen2_x), .screen2_y(screen2_y),
		.depth0(depth0), .depth1(depth1), .depth2(depth2)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// exact sign of dot(vertex0, normal), 66 bits hold the sum
	function automatic bit dot_nonneg(tri_t t);
		logic signed [65:0] acc;
		acc = 66'(longint'(t.c[0]) * longint'(t.c[9]));
		acc = acc + 66'(longint'(t.c[1]) * longint'(t.c[10]));
		acc = acc + 66'(longint'(t.c[2]) * longint'(t.c[11]));
		return acc >= 0;
	endfunction

	function automatic logic signed [tcp_pkg::COORD_W-1:0] project_coord(
		logic signed [tcp_pkg::COORD_W-1:0] c, logic signed [tcp_pkg::COORD_W-1:0] z,
		logic signed [tcp_pkg::COORD_W-1:0] offset);
		longint num, quo, sum;
		num = longint'({33'd0, sh_dist}) * longint'(c);
		quo = (z == 0) ? 64'sd0 : num / longint'(z);
		sum = quo + longint'(offset);
		if (sum > 64'sd2147483647)
			sum = 64'sd2147483647;
		if (sum < -64'sd2147483648)
			sum = -64'sd2147483648;
		return sum[tcp_pkg::COORD_W-1:0];
	endfunction

	// cull flags, projection and window test for one triangle
	function automatic proj_t cull_project(tri_t t);
		proj_t r;
		bit away, near, off;
		longint minx, maxx, miny, maxy, hw, hh, sx, sy;
		near = 1'b0;
		off = 1'b0;
		foreach (r.f[i])
			r.f[i] = '0;
		for (int i = 0; i < 3; i++) begin
			if (longint'(t.c[i*3+2]) < longint'({33'd0, sh_dist}))
				near = 1'b1;
			r.f[9+i] = t.c[i*3+2];
		end
		away = dot_nonneg(t);
		if (!away && !near) begin
			for (int i = 0; i < 3; i++) begin
				r.f[3+i*2] = project_coord(t.c[i*3], t.c[i*3+2], sh_off_x);
				r.f[4+i*2] = project_coord(t.c[i*3+1], t.c[i*3+2], sh_off_y);
			end
			minx = r.f[3];
			maxx = r.f[3];
			miny = r.f[4];
			maxy = r.f[4];
			for (int i = 1; i < 3; i++) begin
				sx = r.f[3+i*2];
				sy = r.f[4+i*2];
				if (sx < minx) minx = sx;
				if (sx > maxx) maxx = sx;
				if (sy < miny) miny = sy;
				if (sy > maxy) maxy = sy;
			end
			hw = longint'({50'd0, sh_win_w}) <<< (tcp_pkg::COORD_FRAC_BITS - 1);
			hh = longint'({50'd0, sh_win_h}) <<< (tcp_pkg::COORD_FRAC_BITS - 1);
			off = !(-hw < maxx && hw > minx && -hh < maxy && hh > miny);
		end
		r.f[0] = {31'd0, away};
		r.f[1] = {31'd0, near};
		r.f[2] = {31'd0, off};
		return r;
	endfunction

	// accept items, predict, check results, watchdog
	always @(posedge clk) begin
		proj_t want, got;
		bit progress;
		progress = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			pending_results = {pending_results, cull_project(cur_tri)};
			n_taken++;
			progress = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			progress = 1'b1;
			got.f = '{{31'd0, facing_away}, {31'd0, too_near}, {31'd0, off_screen},
				screen0_x, screen0_y, screen1_x, screen1_y, screen2_x, screen2_y,
				depth0, depth1, depth2};
			if (pending_results.size() == 0) begin
				$display("%0t: result item with nothing outstanding", $realtime);
				errors++;
			end else begin
				want = pending_results.pop_front();
				foreach (want.f[i])
					if (want.f[i] !== got.f[i]) begin
						$display("%0t: %s expected %0d actual %0d", $realtime,
							field_name[i], want.f[i], got.f[i]);
						errors++;
					end
			end
		end
		if (running && !progress && (in_valid || pending_results.size() != 0))
			stuck_cycles++;
		else
			stuck_cycles = 0;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress, giving up", $realtime);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic send_tri(tri_t t);
		int seen;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		cur_tri = t;
		in_valid = 1'b1;
		seen = n_taken;
		while (n_taken == seen)
			@(negedge clk);
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [tcp_pkg::CFG_IDX_W-1:0] idx,
		logic [tcp_pkg::CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			tcp_pkg::CFG_PLANE_DISTANCE: sh_dist = val[tcp_pkg::DIST_W-1:0];
			tcp_pkg::CFG_PLANE_OFFSET_X: sh_off_x = val;
			tcp_pkg::CFG_PLANE_OFFSET_Y: sh_off_y = val;
			tcp_pkg::CFG_WINDOW_WIDTH:   sh_win_w = val[tcp_pkg::WIN_W-1:0];
			tcp_pkg::CFG_WINDOW_HEIGHT:  sh_win_h = val[tcp_pkg::WIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(logic [31:0] d, logic [31:0] ox, logic [31:0] oy,
		logic [31:0] w, logic [31:0] h);
		write_reg(tcp_pkg::CFG_PLANE_DISTANCE, d);
		write_reg(tcp_pkg::CFG_PLANE_OFFSET_X, ox);
		write_reg(tcp_pkg::CFG_PLANE_OFFSET_Y, oy);
		write_reg(tcp_pkg::CFG_WINDOW_WIDTH, w);
		write_reg(tcp_pkg::CFG_WINDOW_HEIGHT, h);
	endtask

	function automatic row_t mk_row(logic signed [31:0] a [12], bit typed,
		bit away, bit near);
		row_t row;
		row.t.c = a;
		row.typed = typed;
		foreach (row.r.f[i])
			row.r.f[i] = '0;
		row.r.f[0] = {31'd0, away};
		row.r.f[1] = {31'd0, near};
		for (int i = 0; i < 3; i++)
			row.r.f[9+i] = a[i*3+2];
		return row;
	endfunction

	// random triangle, mostly in front of the plane and facing the camera
	function automatic tri_t rand_tri();
		tri_t t;
		longint z;
		int kind;
		kind = $urandom_range(0, 9);
		foreach (t.c[i])
			t.c[i] = $urandom;
		if (kind < 2)
			return t;
		for (int i = 0; i < 3; i++) begin
			t.c[i*3] = $signed(t.c[i*3]) >>> $urandom_range(0, 31);
			t.c[i*3+1] = $signed(t.c[i*3+1]) >>> $urandom_range(0, 31);
			z = longint'({33'd0, sh_dist}) + longint'($urandom >> $urandom_range(0, 31));
			if (kind == 2 && $urandom_range(0, 3) == 0)
				z = longint'({33'd0, sh_dist}) - 1;
			if (z > 64'sd2147483647)
				z = 64'sd2147483647;
			t.c[i*3+2] = z[31:0];
		end
		for (int i = 9; i < 12; i++)
			t.c[i] = $signed(t.c[i]) >>> $urandom_range(0, 31);
		if (kind > 3 && dot_nonneg(t))
			for (int i = 9; i < 12; i++)
				t.c[i] = -t.c[i];
		return t;
	endfunction

	initial begin
		row_t rows [$];
		logic signed [31:0] mx, mn, one;
		logic [31:0] pd [PHASES], pox [PHASES], poy [PHASES], pw [PHASES], ph [PHASES];
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		one = 32'sh00010000;

		// directed triangles under the reset settings
		rows = {rows, mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1, 1)};
		rows = {rows, mk_row('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx},
			1, 1, 0)};
		rows = {rows, mk_row('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn},
			1, 1, 1)};
		rows = {rows, mk_row('{1, 1, one, 0, 0, one, 0, 0, one, 0, 0, 0}, 1, 1, 0)};
		rows = {rows, mk_row('{0, 0, mx, 0, 0, one - 1, 0, 0, mx, 0, 0, -1},
			1, 0, 1)};
		rows = {rows, mk_row('{0, 0, one, 0, 0, one, 0, 0, one, 0, 0, -1}, 0, 0, 0)};
		rows = {rows, mk_row('{-one, -one, one, one, -one, 2*one, 0, one, 3*one,
			0, 0, -one}, 0, 0, 0)};
		rows = {rows, mk_row('{1000*one, 0, one, 1100*one, one, one, 1200*one, 2*one,
			one, 0, 0, -1}, 0, 0, 0)};
		rows = {rows, mk_row('{-1, 0, one, 5, 7, mx, mn, mx, one, 1, 0, 0}, 0, 0, 0)};
		rows = {rows, mk_row('{mn, mn, one, mx, mx, one, mn, mx, one, 0, 0, -one},
			0, 0, 0)};
		rows = {rows, mk_row('{0, 240*one, 2*one, 640*one, 0, 2*one, -640*one,
			-480*one, 2*one, 0, -1, -1}, 0, 0, 0)};

		// settings per phase: extremes, zero distance and zero window among them
		pd = '{32'd65536, 32'd1, 32'h7fffffff, 32'd65536, 32'h00100000, 32'd0,
			32'd65536, 32'h7fffffff};
		pox = '{32'd0, 32'd0, 32'h7fffffff, 32'h80000000, 32'h00050000, 32'd0,
			$urandom, 32'h80000000};
		poy = '{32'd0, 32'd0, 32'h80000000, 32'h7fffffff, 32'hfffb0000, 32'd0,
			$urandom, 32'h7fffffff};
		pw = '{32'd640, 32'd8192, 32'd1, 32'd640, 32'd8192, 32'd0, 32'd97, 32'd8192};
		ph = '{32'd480, 32'd8192, 32'd1, 32'd480, 32'd1, 32'd0, 32'd3001, 32'd1};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		running = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				send_tri(rows[i].t);
				// typed rows override the predictor's entry just queued
				pending_results[pending_results.size()-1] = rows[i].r;
			end else
				send_tri(rows[i].t);
		end
		drain();
		write_reg(CFG_UNUSED, 32'hffffffff);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_regs(pd[p], pox[p], poy[p], pw[p], ph[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == 100)
					drain();
				// stretches with no idling inside each phase
				if (k == 150) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				send_tri(rand_tri());
			end
		end

		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/tcp_pkg.sv
rtl/tcp_div_lane.sv
rtl/triangle_cull_and_project_top.sv
dv/triangle_cull_and_project_top_tb.sv
